// ===== sv/mexp_pkg.sv =====
package mexp_pkg;

	// Width of the modulus, the base, the exponent and the result.
	localparam int MOD_BITS = 48;
	// Width of the index that walks the multiplier bits.
	localparam int IDX_BITS = $clog2(MOD_BITS);

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                load;
		logic                reduce;
		logic                take_pow;
		logic                mult;
		logic                update;
		logic                finish;
		logic [IDX_BITS-1:0] idx;
	} mexp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic exp_zero;
	} mexp_status_t;

	// One step of an MSB-first shift-and-add modular multiply:
	// returns (2*acc + b*a) mod m, given acc < m and a < m.
	function automatic logic [MOD_BITS-1:0] mm_step(
		input logic [MOD_BITS-1:0] acc,
		input logic [MOD_BITS-1:0] a,
		input logic                b,
		input logic [MOD_BITS-1:0] m
	);
		logic [MOD_BITS+1:0] t;
		logic [MOD_BITS+1:0] m1;
		logic [MOD_BITS+1:0] m2;
		t  = {1'b0, acc, 1'b0} + (b ? {2'b00, a} : '0);
		m1 = {2'b00, m};
		m2 = {1'b0, m, 1'b0};
		if (t >= m2) begin
			t = t - m2;
		end else if (t >= m1) begin
			t = t - m1;
		end
		return t[MOD_BITS-1:0];
	endfunction

endpackage

// ===== sv/mexp_dp.sv =====
module mexp_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          modulus_we,
	input  logic [mexp_pkg::MOD_BITS-1:0] modulus_wdata,
	input  logic [mexp_pkg::MOD_BITS-1:0] base_value,
	input  logic [mexp_pkg::MOD_BITS-1:0] exponent_value,
	input  mexp_pkg::mexp_cmd_t           cmd,
	output mexp_pkg::mexp_status_t        status,
	output logic [mexp_pkg::MOD_BITS-1:0] power_result
);
	import mexp_pkg::*;

	logic [MOD_BITS-1:0] m_q;
	logic [MOD_BITS-1:0] base_q;
	logic [MOD_BITS-1:0] exp_q;
	logic [MOD_BITS-1:0] pow_q;
	logic [MOD_BITS-1:0] acc_q;
	logic [MOD_BITS-1:0] pa_q;
	logic [MOD_BITS-1:0] pp_q;
	logic [MOD_BITS-1:0] result_q;
	logic [MOD_BITS-1:0] pp_a;
	logic                pp_b;
	logic [MOD_BITS-1:0] one_w;

	// The effective modulus is kept in the register: values below two become two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_q <= MOD_BITS'(2);
		end else if (modulus_we) begin
			m_q <= (modulus_wdata < MOD_BITS'(2)) ? MOD_BITS'(2) : modulus_wdata;
		end
	end

	assign one_w = MOD_BITS'(1);

	// The squaring unit also reduces the base, as a product of one and the base.
	assign pp_a = cmd.reduce ? one_w : pow_q;
	assign pp_b = cmd.reduce ? base_q[cmd.idx] : pow_q[cmd.idx];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q <= base_value;
			exp_q  <= exponent_value;
			acc_q  <= one_w;
			pp_q   <= '0;
		end
		if (cmd.reduce) begin
			pp_q <= mm_step(pp_q, pp_a, pp_b, m_q);
		end
		if (cmd.take_pow) begin
			pow_q <= pp_q;
			pa_q  <= '0;
			pp_q  <= '0;
		end
		if (cmd.mult) begin
			pa_q <= mm_step(pa_q, acc_q, pow_q[cmd.idx], m_q);
			pp_q <= mm_step(pp_q, pp_a, pp_b, m_q);
		end
		if (cmd.update) begin
			if (exp_q[0]) begin
				acc_q <= pa_q;
			end
			pow_q <= pp_q;
			exp_q <= exp_q >> 1;
			pa_q  <= '0;
			pp_q  <= '0;
		end
		if (cmd.finish) begin
			result_q <= acc_q;
		end
	end

	assign status.exp_zero = (exp_q == '0);
	assign power_result    = result_q;

endmodule

// ===== sv/mexp_ctrl.sv =====
module mexp_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  logic                   out_stall,
	output mexp_pkg::mexp_cmd_t    cmd,
	input  mexp_pkg::mexp_status_t status
);
	import mexp_pkg::*;

	localparam logic [2:0] ST_IDLE    = 3'd0;
	localparam logic [2:0] ST_REDUCE  = 3'd1;
	localparam logic [2:0] ST_SETPOW  = 3'd2;
	localparam logic [2:0] ST_CHECK   = 3'd3;
	localparam logic [2:0] ST_MULT    = 3'd4;
	localparam logic [2:0] ST_UPDATE  = 3'd5;
	localparam logic [2:0] ST_FINISH  = 3'd6;

	localparam logic [IDX_BITS-1:0] IDX_TOP = IDX_BITS'(MOD_BITS - 1);

	logic [2:0]          state_q;
	logic [2:0]          state_d;
	logic [IDX_BITS-1:0] cnt_q;
	logic                out_valid_q;
	logic                in_beat;
	logic                cnt_last;
	logic                can_finish;

	assign in_beat    = in_valid && !in_stall;
	assign cnt_last   = (cnt_q == '0);
	assign can_finish = !out_valid_q || !out_stall;
	assign in_stall   = (state_q != ST_IDLE);
	assign out_valid  = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_REDUCE;
			end
			ST_REDUCE: begin
				if (cnt_last) state_d = ST_SETPOW;
			end
			ST_SETPOW: state_d = ST_CHECK;
			ST_CHECK: begin
				state_d = status.exp_zero ? ST_FINISH : ST_MULT;
			end
			ST_MULT: begin
				if (cnt_last) state_d = ST_UPDATE;
			end
			ST_UPDATE: state_d = ST_CHECK;
			ST_FINISH: begin
				if (can_finish) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.idx      = cnt_q;
		cmd.load     = in_beat;
		cmd.reduce   = (state_q == ST_REDUCE);
		cmd.take_pow = (state_q == ST_SETPOW);
		cmd.mult     = (state_q == ST_MULT);
		cmd.update   = (state_q == ST_UPDATE);
		cmd.finish   = (state_q == ST_FINISH) && can_finish;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= IDX_TOP;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_REDUCE) || (state_q == ST_MULT)) begin
				cnt_q <= cnt_last ? IDX_TOP : cnt_q - 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// A result only appears when the sequencer hands it over.
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result appeared outside the finish step");

	// The bit index never leaves the multiplier width.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= IDX_TOP)
		else $error("bit index out of range");

	// The last multiplier bit always leads into the update step.
	a_mult_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MULT) && cnt_last |=> (state_q == ST_UPDATE))
		else $error("multiply pass did not end in an update");

	// A pending result is never overwritten while the consumer stalls.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(out_valid_q && out_stall))
		else $error("held result overwritten");

	// An accepted beat always starts with the base reduction.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> (state_q == ST_REDUCE) && (cnt_q == IDX_TOP))
		else $error("accepted beat did not start a reduction");

endmodule

// ===== sv/modular_exponentiation_unit.sv =====
// Modular exponentiation unit: for each input beat carrying base_value and
// exponent_value it delivers one output beat with base_value raised to
// exponent_value modulo the programmed modulus, and 1 whenever the exponent is
// zero. The modulus register resets to 2, and any written value below 2 is
// treated as 2; write it only while the unit is idle. The base needs no prior
// reduction. The unit works on one item at a time with two bit-serial
// modular multipliers that handle one multiplier bit per clock. An item first
// reduces the base, then runs through every bit of the exponent up to its
// highest set bit (one check, a pass that forms the multiply and the square
// side by side, one update); a last check leads to the finish step, which waits
// until the previous result has been taken. The finished result sits in an
// output register, so the unit takes the next input beat while that result
// still waits to be taken; in_stall is high whenever an item is in progress.
module modular_exponentiation_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// Modulus register write port.
	input  logic                          modulus_we,
	input  logic [mexp_pkg::MOD_BITS-1:0] modulus_wdata,
	// Input channel.
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mexp_pkg::MOD_BITS-1:0] base_value,
	input  logic [mexp_pkg::MOD_BITS-1:0] exponent_value,
	// Output channel.
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mexp_pkg::MOD_BITS-1:0] power_result
);
	import mexp_pkg::*;

	mexp_cmd_t    cmd;
	mexp_status_t status;

	// The controller sequences reduction, multiply passes and result handover.
	mexp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	// The datapath holds the modulus, the operands and the two
	// shift-and-add modular multiply accumulators.
	mexp_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.modulus_we     (modulus_we),
		.modulus_wdata  (modulus_wdata),
		.base_value     (base_value),
		.exponent_value (exponent_value),
		.cmd            (cmd),
		.status         (status),
		.power_result   (power_result)
	);

endmodule

// ===== tb/modular_exponentiation_unit_tb.sv =====
`timescale 1ns / 100ps

module modular_exponentiation_unit_tb;

	import mexp_pkg::MOD_BITS;

	// The slowest item needs a base reduction and then, for every exponent bit,
	// a check, a multiply pass and an update between its input beat and its result,
	// plus whatever the receiver stalls. The quiet limit is several times that.
	localparam int QUIET_LIMIT   = 10000;
	localparam int RANDOM_PHASES = 9;
	localparam int PHASE_ITEMS   = 78;
	localparam logic [MOD_BITS-1:0] ALL_ONES = '1;

	typedef struct packed {
		logic [MOD_BITS-1:0] base;
		logic [MOD_BITS-1:0] expo;
	} operand_beat_t;

	logic                clk            = 1'b0;
	logic                arst_n         = 1'b0;
	logic                modulus_we     = 1'b0;
	logic [MOD_BITS-1:0] modulus_wdata  = '0;
	logic                in_valid       = 1'b0;
	logic                in_stall;
	logic [MOD_BITS-1:0] base_value     = '0;
	logic [MOD_BITS-1:0] exponent_value = '0;
	logic                out_valid;
	logic                out_stall      = 1'b0;
	logic [MOD_BITS-1:0] power_result;

	// Beats waiting to be offered, and the powers predicted for beats that
	// the unit has already taken.
	operand_beat_t       operand_queue[$];
	logic [MOD_BITS-1:0] expected_powers[$];

	// Copy of the value last written to the modulus register, taken from the
	// write port itself.
	logic [MOD_BITS-1:0] modulus_shadow = 2;

	// Handshake bookkeeping shared between the sampling and driving blocks, the idle patterns, and the counters.
	logic in_taken = 1'b0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   error_count = 0;
	int   quiet_cycles = 0;

	modular_exponentiation_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.modulus_we     (modulus_we),
		.modulus_wdata  (modulus_wdata),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.base_value     (base_value),
		.exponent_value (exponent_value),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.power_result   (power_result)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Right-to-left square-and-multiply. The products are formed at double
	// width and reduced with the plain remainder operator, which is exact and
	// independent of how the hardware builds its products.
	function automatic logic [MOD_BITS-1:0] mod_power(
		input logic [MOD_BITS-1:0] base,
		input logic [MOD_BITS-1:0] expo,
		input logic [MOD_BITS-1:0] modulus_reg
	);
		logic [2*MOD_BITS-1:0] m;
		logic [2*MOD_BITS-1:0] sq;
		logic [2*MOD_BITS-1:0] acc;
		logic [MOD_BITS-1:0]   rest;
		if (expo == '0) begin
			return 1;
		end
		// A modulus register below two behaves as two.
		m    = (modulus_reg < 2) ? 2 : modulus_reg;
		sq   = base % m;
		acc  = 1 % m;
		rest = expo;
		while (rest != '0) begin
			if (rest[0]) begin
				acc = (acc * sq) % m;
			end
			sq   = (sq * sq) % m;
			rest = rest >> 1;
		end
		return acc[MOD_BITS-1:0];
	endfunction

	function automatic logic [MOD_BITS-1:0] rand_word();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[MOD_BITS-1:0];
	endfunction

	// Sampling side. Everything the unit does is observed at the rising edge:
	// accepted input beats produce a prediction, accepted output beats are
	// checked against the oldest prediction, and register writes update the
	// shadow copy of the modulus.
	always @(posedge clk) begin
		if (arst_n) begin
			if (modulus_we) begin
				modulus_shadow = modulus_wdata;
			end
			quiet_cycles++;
			if (in_valid && !in_stall) begin
				expected_powers.insert(expected_powers.size(),
					mod_power(base_value, exponent_value, modulus_shadow));
				in_taken = 1'b1;
				quiet_cycles = 0;
			end
			if (out_valid && !out_stall) begin
				quiet_cycles = 0;
				if (expected_powers.size() == 0) begin
					$error("power_result beat with nothing expected: actual %h",
						power_result);
					error_count++;
				end else if (power_result !== expected_powers[0]) begin
					$error("power_result mismatch: expected %h, actual %h",
						expected_powers[0], power_result);
					error_count++;
					void'(expected_powers.pop_front());
				end else begin
					void'(expected_powers.pop_front());
				end
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Driving side, on the falling edge. A new beat is offered only when the
	// input channel is empty or its beat was just taken, so a stalled beat is
	// held unchanged and valid never looks at the stall. Each signal gets a
	// single assignment per edge, so back-to-back beats keep valid high.
	always @(negedge clk) begin : drive_inputs
		operand_beat_t nxt;
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (operand_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = operand_queue.pop_front();
					in_valid       <= 1'b1;
					base_value     <= nxt.base;
					exponent_value <= nxt.expo;
				end else begin
					in_valid <= 1'b0;
				end
			end
			in_taken = 1'b0;
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic push_operands(input logic [MOD_BITS-1:0] base,
		input logic [MOD_BITS-1:0] expo);
		operand_beat_t b;
		b.base = base;
		b.expo = expo;
		operand_queue.insert(operand_queue.size(), b);
	endtask

	// Holds the sender back until every offered beat is taken and every
	// predicted power has come out. This is checked at the rising edge, where
	// neither the queue nor in_valid can move.
	task automatic wait_drained();
		do begin
			@(posedge clk);
		end while (operand_queue.size() != 0 || in_valid || expected_powers.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// The unit must be idle here, so callers drain first.
	task automatic write_modulus(input logic [MOD_BITS-1:0] value);
		@(negedge clk);
		modulus_we    <= 1'b1;
		modulus_wdata <= value;
		@(negedge clk);
		modulus_we    <= 1'b0;
		modulus_wdata <= rand_word();
	endtask

	// Exponents are mostly short so that the run stays fast; one in ten has
	// a bit length near the full width, which takes every exponent bit
	// through both values.
	function automatic logic [MOD_BITS-1:0] pick_exponent();
		int                  k;
		int                  len;
		logic [MOD_BITS-1:0] mask;
		logic [MOD_BITS-1:0] e;
		k = $urandom_range(99);
		if (k < 8) begin
			return '0;
		end else if (k < 70) begin
			len = $urandom_range(8, 1);
		end else if (k < 90) begin
			len = $urandom_range(20, 9);
		end else begin
			len = $urandom_range(MOD_BITS, 40);
		end
		mask = ALL_ONES >> (MOD_BITS - len);
		e = rand_word() & mask;
		e[len-1] = 1'b1;
		return e;
	endfunction

	// Bases mix values already below the modulus, corner values around it,
	// and full-width values that the unit has to reduce itself.
	function automatic logic [MOD_BITS-1:0] pick_base(input logic [MOD_BITS-1:0] m);
		int k;
		k = $urandom_range(99);
		if (k < 10) begin
			case ($urandom_range(5))
				0: return '0;
				1: return 1;
				2: return ALL_ONES;
				3: return m - 1;
				4: return m;
				default: return m + 1;
			endcase
		end else if (k < 40) begin
			return rand_word() % m;
		end
		return rand_word();
	endfunction

	task automatic queue_random(input int count);
		logic [MOD_BITS-1:0] m;
		m = (modulus_shadow < 2) ? 2 : modulus_shadow;
		repeat (count) begin
			push_operands(pick_base(m), pick_exponent());
		end
	endtask

	initial begin : stimulus
		logic [MOD_BITS-1:0] phase_modulus[RANDOM_PHASES];

		// First idle pattern: the sender pauses now and then, the receiver
		// stalls most of the time.
		send_idle_pct = 22;
		recv_idle_pct = 85;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset modulus of two, never written yet.
		push_operands('0, '0);
		push_operands(ALL_ONES, ALL_ONES);
		push_operands(3, 1);
		wait_drained();

		// A prime modulus: zero exponent with a zero base, zero base with a
		// nonzero exponent, unreduced bases, and both fields at their maximum.
		write_modulus(1000003);
		push_operands('0, '0);
		push_operands('0, 5);
		push_operands(5, '0);
		push_operands(ALL_ONES, 1);
		push_operands(2, ALL_ONES);
		push_operands(1000003, 7);
		push_operands(1000004, 3);
		push_operands(ALL_ONES, ALL_ONES);
		wait_drained();

		// Register values of zero and one both behave as a modulus of two.
		write_modulus('0);
		push_operands(7, 3);
		push_operands(6, 2);
		push_operands(9, '0);
		wait_drained();
		write_modulus(1);
		push_operands(5, 9);
		push_operands(4, '0);
		wait_drained();

		// The largest modulus, where the base of all ones is congruent to zero,
		// and a power of two modulus.
		write_modulus(ALL_ONES);
		push_operands(ALL_ONES, 2);
		push_operands(ALL_ONES - 1, ALL_ONES);
		push_operands({1'b1, {(MOD_BITS-1){1'b0}}}, 3);
		wait_drained();
		write_modulus({1'b1, {(MOD_BITS-1){1'b0}}});
		push_operands(3, ALL_ONES);
		push_operands(ALL_ONES, 5);
		push_operands(2, 47);
		wait_drained();

		phase_modulus[0] = ALL_ONES;
		phase_modulus[1] = 3;
		phase_modulus[2] = rand_word() | {1'b1, {(MOD_BITS-1){1'b0}}};
		phase_modulus[3] = rand_word() & 16'hffff;
		phase_modulus[4] = {1'b1, {(MOD_BITS-2){1'b0}}, 1'b1};
		phase_modulus[5] = rand_word() & 32'hffffffff;
		phase_modulus[6] = 2;
		phase_modulus[7] = rand_word();
		phase_modulus[8] = ALL_ONES - 58;

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			// Swap the idle pattern after the first third, then run the last
			// third with both sides always ready.
			if (p == 3) begin
				send_idle_pct = 85;
				recv_idle_pct = 22;
			end else if (p == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_modulus(phase_modulus[p]);
			if (p == 4) begin
				// Split this phase: the sender sits still until every
				// outstanding power has come back, then carries on.
				queue_random(PHASE_ITEMS / 2);
				wait_drained();
				queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
			end else begin
				queue_random(PHASE_ITEMS);
			end
			wait_drained();
		end

		// Give the unit time to show any stray result before the verdict.
		repeat (64) @(posedge clk);
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/mexp_pkg.sv
sv/mexp_dp.sv
sv/mexp_ctrl.sv
sv/modular_exponentiation_unit.sv
tb/modular_exponentiation_unit_tb.sv
